// ----- rtl/zsub_pkg.sv -----
// ----------------------------------------------------------------------------
// ZMODEM subpacket encoder package
// Shared codes, queue entry layout and the CRC and escape functions.
// ----------------------------------------------------------------------------
package zsub_pkg;

  localparam logic [7:0]  ZDLE_CODE   = 8'h18;
  localparam logic [7:0]  RUB0_CODE   = 8'h6C;
  localparam logic [7:0]  RUB1_CODE   = 8'h6D;
  localparam logic [31:0] CRC32_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC32_POLY  = 32'hEDB8_8320;
  localparam logic [15:0] CRC16_POLY  = 16'h1021;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic REG_CRC32_MODE = 1'b0;
  localparam logic REG_ESC_CTRL   = 1'b1;

  // Back-end position inside an end item.
  localparam logic [2:0] STEP_ZDLE   = 3'd0;
  localparam logic [2:0] STEP_TERM   = 3'd1;
  localparam logic [2:0] STEP_TRAIL0 = 3'd2;
  localparam logic [2:0] STEP_LAST16 = 3'd3;
  localparam logic [2:0] STEP_LAST32 = 3'd5;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  data;
    logic [31:0] trailer;  // trailer bytes, first one in bits 7:0
    logic        mode32;
  } entry_t;

  typedef struct packed {
    logic mode_wr;
    logic mode_val;
    logic mode;
  } front_cfg_t;

  typedef struct packed {
    logic       esc_pend;
    logic [2:0] step;
  } back_stat_t;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] c, input logic after_at,
                                        input logic esc_ctrl);
    logic [6:0] c7;
    c7 = c[6:0];
    return (c == ZDLE_CODE) || (c7 == 7'h10) || (c7 == 7'h11) || (c7 == 7'h13) ||
           (c7 == 7'h7F) || (c7 == 7'h1D) || ((c7 == 7'h0D) && after_at) ||
           ((c7[6:5] == 2'b00) && esc_ctrl);
  endfunction

  function automatic logic [7:0] escaped_char(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h7F:   r = RUB0_CODE;
      8'hFF:   r = RUB1_CODE;
      default: r = c ^ 8'h40;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/zsub_front.sv -----
// ----------------------------------------------------------------------------
// ZMODEM subpacket encoder front end
// Accepts input items, folds each byte into the running CRC and queues a
// command for the back end; end items carry the finished trailer.
// ----------------------------------------------------------------------------
module zsub_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [7:0]           byte_value,
  input  zsub_pkg::front_cfg_t cfg,
  input  logic                 fifo_full,
  output logic                 push,
  output zsub_pkg::entry_t     push_entry
);
  import zsub_pkg::*;

  logic [31:0] crc_reg;
  logic [31:0] crc_fold_val;
  logic [15:0] crc16_val;

  assign crc16_val    = crc16_fold(crc_reg[15:0], byte_value);
  assign crc_fold_val = cfg.mode ? crc32_fold(crc_reg, byte_value) : {16'h0, crc16_val};

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_entry.is_end = (action == ACT_END);
    push_entry.data   = byte_value;
    push_entry.mode32 = cfg.mode;
    // CRC-32 goes out complemented low byte first, CRC-16 high byte first.
    push_entry.trailer = cfg.mode ? ~crc_fold_val
                                  : {16'h0, crc_fold_val[7:0], crc_fold_val[15:8]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= '0;
    end else if (cfg.mode_wr) begin
      crc_reg <= cfg.mode_val ? CRC32_INIT : '0;
    end else if (push) begin
      if (action == ACT_END) begin
        crc_reg <= cfg.mode ? CRC32_INIT : '0;
      end else begin
        crc_reg <= crc_fold_val;
      end
    end
  end

endmodule

// ----- rtl/zsub_fifo.sv -----
// ----------------------------------------------------------------------------
// ZMODEM subpacket encoder command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module zsub_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  zsub_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output zsub_pkg::entry_t head
);
  import zsub_pkg::*;

  entry_t     q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/zsub_back.sv -----
// ----------------------------------------------------------------------------
// ZMODEM subpacket encoder back end
// Walks the head command byte by byte, applies ZDLE escaping and drives the
// output register, one line byte per cycle unless out_ready stalls it.
// ----------------------------------------------------------------------------
module zsub_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  zsub_pkg::entry_t     head,
  input  logic                 esc_ctrl,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 last,
  output zsub_pkg::back_stat_t stat
);
  import zsub_pkg::*;

  logic       esc_pend;
  logic       esc_pend_next;
  logic [2:0] step;
  logic [2:0] step_next;
  logic       after_at;
  logic       after_at_next;
  logic [7:0] out_byte_next;
  logic       last_next;

  logic       load;
  logic [1:0] trail_idx;
  logic [7:0] cur;
  logic       escapable;
  logic       final_step;
  logic       esc;
  logic       done;

  assign load      = head_valid && (!out_valid || out_ready);
  assign trail_idx = 2'(step - STEP_TRAIL0);
  assign escapable = !head.is_end || (step >= STEP_TRAIL0);
  assign final_step = !head.is_end ||
                      (step == (head.mode32 ? STEP_LAST32 : STEP_LAST16));

  always_comb begin
    if (!head.is_end) begin
      cur = head.data;
    end else begin
      case (step)
        STEP_ZDLE: cur = ZDLE_CODE;
        STEP_TERM: cur = head.data;
        default:   cur = 8'(head.trailer >> {trail_idx, 3'b000});
      endcase
    end
  end

  assign esc = escapable && needs_escape(cur, after_at, esc_ctrl);

  always_comb begin
    out_byte_next = cur;
    last_next     = 1'b0;
    esc_pend_next = esc_pend;
    step_next     = step;
    after_at_next = after_at;
    pop           = 1'b0;
    done          = 1'b0;
    if (load) begin
      if (esc_pend) begin
        out_byte_next = escaped_char(cur);
        done          = 1'b1;
      end else if (esc) begin
        out_byte_next = ZDLE_CODE;
        esc_pend_next = 1'b1;
      end else begin
        done = 1'b1;
      end
    end
    if (done) begin
      esc_pend_next = 1'b0;
      // Only bytes on the escape path track the CR-after-'@' rule.
      if (escapable) begin
        after_at_next = (cur[6:0] == 7'h40);
      end
      if (final_step) begin
        last_next = 1'b1;
        pop       = 1'b1;
        step_next = STEP_ZDLE;
      end else begin
        step_next = step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      esc_pend  <= 1'b0;
      step      <= STEP_ZDLE;
      after_at  <= 1'b0;
    end else begin
      esc_pend <= esc_pend_next;
      step     <= step_next;
      after_at <= after_at_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= out_byte_next;
      last     <= last_next;
    end
  end

  assign stat.esc_pend = esc_pend;
  assign stat.step     = step;

endmodule

// ----- rtl/zmodem_escaped_subpacket_encoder.sv -----
// ----------------------------------------------------------------------------
// ZMODEM escaped subpacket encoder
// Escapes payload bytes for the line and closes subpackets with a ZDLE,
// the terminator and an escaped CRC-16 or CRC-32 trailer.
// ----------------------------------------------------------------------------
// An item is folded into the CRC and queued as it is transferred in; the back
// end loads its line bytes from the queue head into the output register.
// Throughput: the back end sends one line byte per cycle unless out_ready holds
// it or the queue is empty; a payload byte makes one or two line bytes and an
// end item four to ten. The front end takes one item per cycle while the
// two-entry queue has room.
// Reset (rst, synchronous): control state to zero, CRC-16 mode, queue empty.
// ----------------------------------------------------------------------------
module zmodem_escaped_subpacket_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);
  import zsub_pkg::*;

  logic       crc32_mode;
  logic       escape_controls;
  front_cfg_t front_cfg;
  logic       fifo_full;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       head_valid;
  entry_t     head;
  back_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc32_mode      <= 1'b0;
      escape_controls <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRC32_MODE: crc32_mode      <= cfg_data;
        REG_ESC_CTRL:   escape_controls <= cfg_data;
        default:        crc32_mode      <= crc32_mode;
      endcase
    end
  end

  assign front_cfg.mode_wr  = cfg_we && (cfg_index == REG_CRC32_MODE);
  assign front_cfg.mode_val = cfg_data;
  assign front_cfg.mode     = crc32_mode;

  zsub_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .byte_value (byte_value),
    .cfg        (front_cfg),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry)
  );

  zsub_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head       (head)
  );

  zsub_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .esc_ctrl   (escape_controls),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last),
    .stat       (stat)
  );

  // A pending escape always sits behind a ZDLE in the output register.
  assert property (@(posedge clk) disable iff (rst)
    stat.esc_pend |-> (!out_valid || (out_byte == ZDLE_CODE)))
    else $error("escape pending without a ZDLE in the output register");

  // The final byte of an item never leaves an escape half done.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> !stat.esc_pend)
    else $error("last byte sent with an escape still pending");

  // The back end never walks past the last CRC-32 trailer byte.
  assert property (@(posedge clk) disable iff (rst)
    stat.step <= STEP_LAST32)
    else $error("back end step out of range");

  // The queue only drains through a byte that finishes an item.
  assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && last))
    else $error("queue popped without marking the last byte");

endmodule

// ----- test/tb_zmodem_escaped_subpacket_encoder.sv -----
// ----------------------------------------------------------------------------
// Testbench for the ZMODEM escaped subpacket encoder
// A short table of directed items (escape cases, extremes and both trailer
// modes) runs first. Random subpackets follow under random idling on both
// sides and random register settings. Every line byte is compared with a
// local CRC and escape predictor, or with a directed row's hand-typed bytes.
// ----------------------------------------------------------------------------
module tb_zmodem_escaped_subpacket_encoder;
  import zsub_pkg::*;

  localparam int RANDOM_ITEMS = 195;
  localparam int CALM_ITEMS   = 40;
  localparam int QUIET_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_byte_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  // For a write row, sel is the register index and val[0] the value.
  typedef struct {
    row_kind_t  kind;
    logic       sel;
    logic [7:0] val;
    int         typed_n;
    logic [7:0] t0;
    logic [7:0] t1;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = ACT_DATA;
  logic [7:0] byte_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_CRC32_MODE;
  logic       cfg_data = 1'b0;

  // Hand-typed line bytes for the item on the bus, driven along with it.
  int         typed_n = 0;
  logic [7:0] typed_b0 = 8'h00;
  logic [7:0] typed_b1 = 8'h00;

  // Predictor state.
  logic        mdl_crc32 = 1'b0;
  logic        mdl_esc_ctrl = 1'b0;
  logic        mdl_after_at = 1'b0;
  logic [31:0] mdl_crc = 32'h0;

  line_byte_t  line_q[$];
  line_byte_t  item_bytes[$];
  stim_row_t   directed_rows[$];

  int errors = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  zmodem_escaped_subpacket_encoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void crc_restart();
    mdl_crc = mdl_crc32 ? CRC32_INIT : 32'h0;
  endfunction

  // Bit-serial form: the feedback is the outgoing CRC bit xor the data bit.
  function automatic void crc_absorb(input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      if (mdl_crc32) begin
        fb = mdl_crc[0] ^ b[i];
        mdl_crc = {1'b0, mdl_crc[31:1]} ^ (fb ? CRC32_POLY : 32'h0);
      end else begin
        fb = mdl_crc[15] ^ b[7 - i];
        mdl_crc = {16'h0, mdl_crc[14:0], 1'b0} ^ (fb ? {16'h0, CRC16_POLY} : 32'h0);
      end
    end
  endfunction

  function automatic void line_push(input logic [7:0] c);
    item_bytes.push_back('{c, 1'b0});
  endfunction

  function automatic void push_escaped(input logic [7:0] c);
    logic [6:0] low7;
    logic       esc;
    low7 = c[6:0];
    esc = (c == ZDLE_CODE) || (mdl_esc_ctrl && (low7 < 7'h20));
    case (low7)
      7'h10, 7'h11, 7'h13, 7'h1D, 7'h7F: esc = 1'b1;
      7'h0D: begin
        if (mdl_after_at) esc = 1'b1;
      end
      default: ;
    endcase
    if (!esc) begin
      line_push(c);
    end else begin
      line_push(ZDLE_CODE);
      if (c == 8'h7F) line_push(RUB0_CODE);
      else if (c == 8'hFF) line_push(RUB1_CODE);
      else line_push(c ^ 8'h40);
    end
    mdl_after_at = (low7 == 7'h40);
  endfunction

  // Line bytes caused by one item, left in item_bytes.
  function automatic void predict_line_bytes(input logic act, input logic [7:0] v);
    logic [31:0] trail;
    line_byte_t  tail;
    item_bytes.delete();
    if (act == ACT_DATA) begin
      crc_absorb(v);
      push_escaped(v);
    end else begin
      // The terminator goes out raw and leaves the '@' tracking alone.
      line_push(ZDLE_CODE);
      crc_absorb(v);
      line_push(v);
      if (mdl_crc32) begin
        trail = ~mdl_crc;
        for (int k = 0; k < 4; k++) push_escaped(trail[8*k +: 8]);
      end else begin
        push_escaped(mdl_crc[15:8]);
        push_escaped(mdl_crc[7:0]);
      end
      crc_restart();
    end
    tail = item_bytes.pop_back();
    tail.last = 1'b1;
    item_bytes.push_back(tail);
  endfunction

  function automatic void apply_write(input logic idx, input logic d);
    if (idx == REG_CRC32_MODE) begin
      mdl_crc32 = d;
      crc_restart();
    end else begin
      mdl_esc_ctrl = d;
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Transfers on both channels, register writes and the watchdog.
  always @(posedge clk) begin
    line_byte_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (line_q.size() == 0) begin
          report_mismatch($sformatf("line byte %02h with nothing expected", out_byte));
        end else begin
          want = line_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
          if (last !== want.last)
            report_mismatch($sformatf("last %b, expected %b on byte %02h",
                                      last, want.last, want.data));
        end
      end
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        predict_line_bytes(action, byte_value);
        if (typed_n != 0) begin
          item_bytes.delete();
          if (typed_n == 1) begin
            item_bytes.push_back('{typed_b0, 1'b1});
          end else begin
            item_bytes.push_back('{typed_b0, 1'b0});
            item_bytes.push_back('{typed_b1, 1'b1});
          end
        end
        foreach (item_bytes[k]) line_q.push_back(item_bytes[k]);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("no transfer for %0d cycles", QUIET_LIMIT);
          $display("tb_zmodem_escaped_subpacket_encoder failed");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, none once the run is calm.
  initial begin
    int unsigned span;
    @(posedge clk);
    forever begin
      if (calm || ($urandom_range(0, 3) != 0)) begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 7);
      end
      repeat (span) @(posedge clk);
    end
  end

  task automatic send_item(input logic act, input logic [7:0] val, input int n_typed,
                           input logic [7:0] t0, input logic [7:0] t1);
    if (!calm && ($urandom_range(0, 3) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    byte_value <= val;
    typed_n    <= n_typed;
    typed_b0   <= t0;
    typed_b1   <= t1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (line_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_payload();
    logic [7:0] hot[8];
    logic [7:0] v;
    hot = '{8'h18, 8'h10, 8'h11, 8'h13, 8'h1D, 8'h7F, 8'h0D, 8'h40};
    case ($urandom_range(0, 5))
      0, 1: v = hot[$urandom_range(0, 7)] | {1'($urandom_range(0, 1)), 7'h00};
      2: v = {1'($urandom_range(0, 1)), 2'b00, 5'($urandom_range(0, 31))};
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  initial begin
    int  rand_goal;
    int  pkt_len;
    bit  paused;
    stim_row_t row;
    paused = 1'b0;

    // After reset: CRC-16 trailer, controls not escaped.
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h00, 1, 8'h00,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'hFF, 2, ZDLE_CODE, RUB1_CODE});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h7F, 2, ZDLE_CODE, RUB0_CODE});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h18, 2, ZDLE_CODE, 8'h58});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h98, 1, 8'h98,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h10, 2, ZDLE_CODE, 8'h50});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h93, 2, ZDLE_CODE, 8'hD3});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h9D, 2, ZDLE_CODE, 8'hDD});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h0D, 1, 8'h0D,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h40, 1, 8'h40,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h8D, 2, ZDLE_CODE, 8'hCD});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'hC0, 1, 8'hC0,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h0D, 2, ZDLE_CODE, 8'h4D});
    directed_rows.push_back('{ROW_ITEM,  ACT_END,  8'h68, 0, 8'h00,    8'h00});
    // The '@' tracking carries over into the next subpacket.
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h40, 1, 8'h40,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_END,  8'h00, 0, 8'h00,    8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_ESC_CTRL,   8'h01, 0, 8'h00, 8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h01, 2, ZDLE_CODE, 8'h41});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h98, 2, ZDLE_CODE, 8'hD8});
    directed_rows.push_back('{ROW_ITEM,  ACT_END,  8'hFF, 0, 8'h00,    8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_CRC32_MODE, 8'h01, 0, 8'h00, 8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h31, 1, 8'h31,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_END,  8'h6B, 0, 8'h00,    8'h00});
    // A mode write in the middle of a subpacket restarts the CRC.
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'h55, 1, 8'h55,    8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_CRC32_MODE, 8'h00, 0, 8'h00, 8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_DATA, 8'hAA, 1, 8'hAA,    8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_END,  8'h6A, 0, 8'h00,    8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_CRC32_MODE, 8'h01, 0, 8'h00, 8'h00});
    directed_rows.push_back('{ROW_ITEM,  ACT_END,  8'h69, 0, 8'h00,    8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_CRC32_MODE, 8'h00, 0, 8'h00, 8'h00});
    directed_rows.push_back('{ROW_WRITE, REG_ESC_CTRL,   8'h00, 0, 8'h00, 8'h00});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_reg(row.sel, row.val[0]);
      else send_item(row.sel, row.val, row.typed_n, row.t0, row.t1);
    end

    // Random subpackets: mostly well formed, some left open.
    rand_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < rand_goal) begin
      if (items_sent >= rand_goal - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_CRC32_MODE, 1'($urandom_range(0, 1)));
        write_reg(REG_ESC_CTRL, 1'($urandom_range(0, 1)));
      end
      pkt_len = $urandom_range(0, 12);
      for (int k = 0; k < pkt_len; k++) begin
        if ($urandom_range(0, 39) == 0) write_reg(REG_CRC32_MODE, 1'($urandom_range(0, 1)));
        send_item(ACT_DATA, pick_payload(), 0, 8'h00, 8'h00);
      end
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 3) == 0)
          send_item(ACT_END, 8'($urandom_range(0, 255)), 0, 8'h00, 8'h00);
        else
          send_item(ACT_END, 8'($urandom_range(8'h68, 8'h6B)), 0, 8'h00, 8'h00);
      end
      if (!paused && (items_sent >= rand_goal - RANDOM_ITEMS / 2)) begin
        // Hold the sender until the line has caught up completely.
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_zmodem_escaped_subpacket_encoder passed");
    end else begin
      $display("tb_zmodem_escaped_subpacket_encoder failed");
    end
    $finish;
  end

endmodule
